[src/drs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_pkg
// Shared constants, types and state codes of the decimal radix sorter.
// ----------------------------------------------------------------------------
package drs_pkg;

	localparam int CAPACITY    = 64;
	localparam int KEY_W       = 31;
	localparam int ADDR_W      = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int RADIX       = 10;
	localparam int DIG_W       = $clog2(RADIX);
	localparam int RECIP_W     = 32;
	localparam int RECIP_SHIFT = 35;
	localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		key_t key;
		key_t quo;
	} sort_word_t;

	localparam int WORD_W = $bits(sort_word_t);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_HIST,
		ST_PREFIX,
		ST_SCAT,
		ST_NEXT,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} state_t;

endpackage
`default_nettype wire

[src/drs_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_in_if
// Key channel: one request carries one key and its end-of-set flag.
// ----------------------------------------------------------------------------
interface drs_in_if;
	logic          valid;
	logic          ready;
	drs_pkg::key_t key;
	logic          final_item;

	modport source (output valid, output key, output final_item, input ready);
	modport sink (input valid, input key, input final_item, output ready);
endinterface
`default_nettype wire

[src/drs_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_out_if
// Result channel: one request carries one sorted key and its flags.
// ----------------------------------------------------------------------------
interface drs_out_if;
	logic          valid;
	logic          ready;
	drs_pkg::key_t sorted_key;
	logic          end_of_run;
	logic          dropped_any;

	modport source (output valid, output sorted_key, output end_of_run,
		output dropped_any, input ready);
	modport sink (input valid, input sorted_key, input end_of_run,
		input dropped_any, output ready);
endinterface
`default_nettype wire

[src/drs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module drs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[src/drs_digit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drs_digit
// Splits a value into its quotient by ten and its lowest decimal digit.
// ----------------------------------------------------------------------------
module drs_digit (
	input  wire logic                        clk,
	input  wire drs_pkg::key_t               value,
	input  wire drs_pkg::key_t               tag,
	output drs_pkg::key_t                    quo_s1,
	output drs_pkg::key_t                    tag_s1,
	output logic [drs_pkg::DIG_W-1:0]        digit
);

	localparam int PROD_W = drs_pkg::KEY_W + drs_pkg::RECIP_W;

	logic [PROD_W-1:0] prod;
	drs_pkg::key_t     value_s1;
	drs_pkg::key_t     rem;

	assign prod = PROD_W'(value) * PROD_W'(drs_pkg::RECIP);

	always_ff @(posedge clk) begin
		quo_s1   <= drs_pkg::KEY_W'(prod >> drs_pkg::RECIP_SHIFT);
		value_s1 <= value;
		tag_s1   <= tag;
	end

	assign rem   = value_s1 - ((quo_s1 << 3) + (quo_s1 << 1));
	assign digit = rem[drs_pkg::DIG_W-1:0];

endmodule
`default_nettype wire

[src/decimal_radix_sort.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_radix_sort
// Least-significant-digit decimal radix sorter for sets of up to 64 keys.
// ----------------------------------------------------------------------------
// Keys are taken one per cycle until the request flagged final; keys beyond
// capacity are dropped and reported on every result of the set. The sort
// then runs one pass per decimal digit of the largest key, reading every key
// twice per pass through the single read port of the key memories (histogram,
// then scatter) while the prefix sum walks the ten counters in between. Each
// result passes through the states ST_OUT_RD, ST_OUT_LD and ST_OUT_WAIT, and
// no new key is taken until the last result has gone.
module decimal_radix_sort (
	input  wire logic  clk,
	input  wire logic  arst_n,
	drs_in_if.sink     loader,
	drs_out_if.source  result
);

	drs_pkg::state_t state_q, state_d;

	logic [drs_pkg::CNT_W-1:0]  cnt_q;
	logic [drs_pkg::CNT_W-1:0]  iss_q;
	logic [drs_pkg::ADDR_W-1:0] out_idx_q;
	logic [drs_pkg::DIG_W-1:0]  pidx_q;
	logic [drs_pkg::CNT_W-1:0]  run_q;
	logic [drs_pkg::CNT_W-1:0]  digit_counts [drs_pkg::RADIX];
	drs_pkg::key_t              lq_q;
	logic                       ovf_q;
	logic                       sel_q;
	logic                       rd_v_s1;
	logic                       dg_v_s2;

	logic                       out_v_q;
	drs_pkg::key_t              out_key_q;
	logic                       out_end_q;
	logic                       out_drop_q;

	logic                       rd_en;
	logic [drs_pkg::ADDR_W-1:0] rd_addr;
	logic                       load_acc;
	logic                       load_store;
	drs_pkg::sort_word_t        a_rdata, b_rdata, src_rdata;
	drs_pkg::sort_word_t        a_wdata, scat_word;
	logic                       a_we, b_we;
	logic [drs_pkg::ADDR_W-1:0] a_waddr, slot;
	drs_pkg::key_t              dg_quo, dg_key, lq_quo, lq_tag;
	logic [drs_pkg::DIG_W-1:0]  dg_digit, lq_digit;
	logic [drs_pkg::DIG_W-1:0]  cnt_addr;
	logic [drs_pkg::CNT_W-1:0]  cnt_rd;
	logic                       scat_wr;
	logic                       out_last;

	assign load_acc   = loader.valid && loader.ready;
	assign load_store = load_acc && (cnt_q < drs_pkg::CNT_W'(drs_pkg::CAPACITY));
	assign src_rdata  = sel_q ? b_rdata : a_rdata;
	assign cnt_addr   = (state_q == drs_pkg::ST_PREFIX) ? pidx_q : dg_digit;
	assign cnt_rd     = digit_counts[cnt_addr];
	assign slot       = drs_pkg::ADDR_W'(cnt_rd - 1'b1);
	assign scat_wr    = (state_q == drs_pkg::ST_SCAT) && dg_v_s2;
	assign scat_word  = '{key: dg_key, quo: dg_quo};
	assign out_last   = (drs_pkg::CNT_W'(out_idx_q) + 1'b1) == cnt_q;

	assign a_we    = load_store || (scat_wr && sel_q);
	assign b_we    = scat_wr && !sel_q;
	assign a_waddr = (state_q == drs_pkg::ST_LOAD) ? drs_pkg::ADDR_W'(cnt_q) : slot;
	assign a_wdata = (state_q == drs_pkg::ST_LOAD) ?
		drs_pkg::sort_word_t'{key: loader.key, quo: loader.key} : scat_word;

	drs_ram #(.WIDTH(drs_pkg::WORD_W), .DEPTH(drs_pkg::CAPACITY)) u_key_store (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (a_rdata)
	);

	drs_ram #(.WIDTH(drs_pkg::WORD_W), .DEPTH(drs_pkg::CAPACITY)) u_scatter_store (
		.clk   (clk),
		.we    (b_we),
		.waddr (slot),
		.wdata (scat_word),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (b_rdata)
	);

	drs_digit u_key_digit (
		.clk    (clk),
		.value  (src_rdata.quo),
		.tag    (src_rdata.key),
		.quo_s1 (dg_quo),
		.tag_s1 (dg_key),
		.digit  (dg_digit)
	);

	drs_digit u_max_digit (
		.clk    (clk),
		.value  (lq_q),
		.tag    (lq_q),
		.quo_s1 (lq_quo),
		.tag_s1 (lq_tag),
		.digit  (lq_digit)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			drs_pkg::ST_LOAD: begin
				if (load_acc && loader.final_item) begin
					state_d = drs_pkg::ST_CHECK;
				end
			end
			drs_pkg::ST_CHECK: begin
				state_d = (lq_q != '0) ? drs_pkg::ST_HIST : drs_pkg::ST_OUT_RD;
			end
			drs_pkg::ST_HIST: begin
				if (iss_q == cnt_q && !rd_v_s1 && !dg_v_s2) begin
					state_d = drs_pkg::ST_PREFIX;
				end
			end
			drs_pkg::ST_PREFIX: begin
				if (pidx_q == drs_pkg::DIG_W'(drs_pkg::RADIX - 1)) begin
					state_d = drs_pkg::ST_SCAT;
				end
			end
			drs_pkg::ST_SCAT: begin
				if (iss_q == '0 && !rd_v_s1 && !dg_v_s2) begin
					state_d = drs_pkg::ST_NEXT;
				end
			end
			drs_pkg::ST_NEXT:    state_d = drs_pkg::ST_CHECK;
			drs_pkg::ST_OUT_RD:  state_d = drs_pkg::ST_OUT_LD;
			drs_pkg::ST_OUT_LD:  state_d = drs_pkg::ST_OUT_WAIT;
			drs_pkg::ST_OUT_WAIT: begin
				if (result.ready) begin
					state_d = out_end_q ? drs_pkg::ST_LOAD : drs_pkg::ST_OUT_RD;
				end
			end
			default: state_d = drs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		loader.ready = (state_q == drs_pkg::ST_LOAD);
		rd_en        = 1'b0;
		rd_addr      = out_idx_q;
		unique case (state_q)
			drs_pkg::ST_HIST: begin
				rd_en   = (iss_q != cnt_q);
				rd_addr = drs_pkg::ADDR_W'(iss_q);
			end
			drs_pkg::ST_SCAT: begin
				rd_en   = (iss_q != '0);
				rd_addr = drs_pkg::ADDR_W'(iss_q - 1'b1);
			end
			drs_pkg::ST_OUT_RD: rd_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= drs_pkg::ST_LOAD;
			cnt_q     <= '0;
			iss_q     <= '0;
			out_idx_q <= '0;
			pidx_q    <= '0;
			run_q     <= '0;
			lq_q      <= '0;
			ovf_q     <= 1'b0;
			sel_q     <= 1'b0;
			rd_v_s1   <= 1'b0;
			dg_v_s2   <= 1'b0;
			out_v_q   <= 1'b0;
			for (int i = 0; i < drs_pkg::RADIX; i++) begin
				digit_counts[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en && (state_q == drs_pkg::ST_HIST || state_q == drs_pkg::ST_SCAT);
			dg_v_s2 <= rd_v_s1;
			unique case (state_q)
				drs_pkg::ST_LOAD: begin
					if (load_store) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == '0 || loader.key > lq_q) begin
							lq_q <= loader.key;
						end
					end else if (load_acc) begin
						ovf_q <= 1'b1;
					end
				end
				drs_pkg::ST_CHECK: begin
					iss_q     <= '0;
					pidx_q    <= '0;
					run_q     <= '0;
					out_idx_q <= '0;
					for (int i = 0; i < drs_pkg::RADIX; i++) begin
						digit_counts[i] <= '0;
					end
				end
				drs_pkg::ST_HIST: begin
					if (rd_en) begin
						iss_q <= iss_q + 1'b1;
					end
					if (dg_v_s2) begin
						digit_counts[cnt_addr] <= cnt_rd + 1'b1;
					end
				end
				drs_pkg::ST_PREFIX: begin
					digit_counts[cnt_addr] <= cnt_rd + run_q;
					run_q  <= cnt_rd + run_q;
					pidx_q <= pidx_q + 1'b1;
					iss_q  <= cnt_q;
				end
				drs_pkg::ST_SCAT: begin
					if (rd_en) begin
						iss_q <= iss_q - 1'b1;
					end
					if (dg_v_s2) begin
						digit_counts[cnt_addr] <= cnt_rd - 1'b1;
					end
				end
				drs_pkg::ST_NEXT: begin
					sel_q <= !sel_q;
					lq_q  <= lq_quo;
				end
				drs_pkg::ST_OUT_LD: begin
					out_v_q <= 1'b1;
				end
				drs_pkg::ST_OUT_WAIT: begin
					if (result.ready) begin
						out_v_q   <= 1'b0;
						out_idx_q <= out_idx_q + 1'b1;
						if (out_end_q) begin
							cnt_q <= '0;
							lq_q  <= '0;
							ovf_q <= 1'b0;
							sel_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == drs_pkg::ST_OUT_LD) begin
			out_key_q  <= src_rdata.key;
			out_end_q  <= out_last;
			out_drop_q <= ovf_q;
		end
	end

	assign result.valid       = out_v_q;
	assign result.sorted_key  = out_key_q;
	assign result.end_of_run  = out_end_q;
	assign result.dropped_any = out_drop_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= drs_pkg::CNT_W'(drs_pkg::CAPACITY))
		else $error("stored key count beyond capacity");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		dg_v_s2 |-> dg_digit < drs_pkg::DIG_W'(drs_pkg::RADIX))
		else $error("decimal digit out of range");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		scat_wr |-> cnt_rd != '0)
		else $error("scatter slot underflow");

	a_max_split: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drs_pkg::ST_NEXT |->
			lq_tag == lq_q && lq_digit < drs_pkg::DIG_W'(drs_pkg::RADIX))
		else $error("largest key split is stale");

	a_end_returns: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.end_of_run |=> state_q == drs_pkg::ST_LOAD)
		else $error("sorter did not return to loading after the last result");

endmodule
`default_nettype wire
